@@ sv/abpa_pkg.sv @@
package abpa_pkg;

  // bitmap geometry
  localparam int BITMAP_WIDTH  = 240;
  localparam int BITMAP_HEIGHT = 160;

  // field widths
  localparam int COL_W      = 8;
  localparam int REF_W      = 28;
  localparam int ACC_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int STEP_W     = 16;
  localparam int ADDR_W     = 17;
  localparam int MW_W       = 5;
  localparam int LOFS_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int PX_W  = (BITMAP_WIDTH > 1) ? $clog2(BITMAP_WIDTH) : 1;
  localparam int PY_W  = (BITMAP_HEIGHT > 1) ? $clog2(BITMAP_HEIGHT) : 1;
  localparam int CNT_W = $clog2(COL_W);

  localparam logic [ADDR_W-1:0] FRAME_OFFSET = 'hA000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AFFINE_ENABLE = 3'd0,
    REG_MOSAIC_ENABLE = 3'd1,
    REG_MOSAIC_WIDTH  = 3'd2,
    REG_LINE_OFFSET   = 3'd3,
    REG_STEP_X        = 3'd4,
    REG_STEP_Y        = 3'd5,
    REG_FRAME_SELECT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                     affine_enable;
    logic                     mosaic_enable;
    logic [MW_W-1:0]          mosaic_width;
    logic [LOFS_W-1:0]        line_offset;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic                     frame_select;
  } abpa_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              inside_res;
  } abpa_res_t;

endpackage

@@ sv/abpa_in_if.sv @@
interface abpa_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [abpa_pkg::COL_W-1:0]        column;
  logic signed [abpa_pkg::REF_W-1:0] ref_x;
  logic signed [abpa_pkg::REF_W-1:0] ref_y;

  modport source (output valid, func, column, ref_x, ref_y, input ready);
  modport sink   (input valid, func, column, ref_x, ref_y, output ready);
endinterface

@@ sv/abpa_out_if.sv @@
interface abpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [abpa_pkg::ADDR_W-1:0] address;
  logic                        inside_res;

  modport source (output valid, address, inside_res, input ready);
  modport sink   (input valid, address, inside_res, output ready);
endinterface

@@ sv/abpa_alu.sv @@
module abpa_alu (
  input  logic [abpa_pkg::ACC_W-1:0] alu_a,
  input  logic [abpa_pkg::ACC_W-1:0] alu_b,
  input  logic                       alu_sub,
  output logic [abpa_pkg::ACC_W-1:0] alu_sum
);
  import abpa_pkg::*;

  // a + b, or a - b as a + ~b + 1
  assign alu_sum = alu_a + (alu_b ^ {ACC_W{alu_sub}}) + ACC_W'(alu_sub);

endmodule

@@ sv/abpa_core.sv @@
module abpa_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  abpa_pkg::abpa_cfg_t               cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [abpa_pkg::COL_W-1:0]        in_column,
  input  logic signed [abpa_pkg::REF_W-1:0] in_ref_x,
  input  logic signed [abpa_pkg::REF_W-1:0] in_ref_y,
  input  logic                              out_free,
  output logic                              res_load,
  output abpa_pkg::abpa_res_t               res
);
  import abpa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_AX    = 8'b0000_0010,
    S_AY    = 8'b0000_0100,
    S_ADDX  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_MSUB  = 8'b0010_0000,
    S_LOFS  = 8'b0100_0000,
    S_FRAME = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ACC_W-1:0]   acc_x_r, acc_x_nxt;
  logic [ACC_W-1:0]   acc_y_r, acc_y_nxt;
  logic [PX_W-1:0]    px_r, px_nxt;
  logic [PY_W-1:0]    py_r, py_nxt;
  logic               inside_r, inside_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [MW_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  res_r, res_nxt;

  logic [ACC_W-1:0]   alu_a, alu_b, alu_sum;
  logic               alu_sub;
  logic [ACC_W-1:0]   row_base;
  logic [MW_W:0]      trial;
  logic               in_bounds;

  abpa_alu u_alu (
    .alu_a   (alu_a),
    .alu_b   (alu_b),
    .alu_sub (alu_sub),
    .alu_sum (alu_sum)
  );

  assign in_ready = (state_r == S_IDLE);
  assign row_base = ACC_W'(py_r) * ACC_W'(BITMAP_WIDTH);
  assign trial    = {rem_r, col_r[cnt_r]};

  // floor coordinate taken from the accumulators before they step
  assign in_bounds = !acc_x_r[ACC_W-1] && !acc_y_r[ACC_W-1] &&
                     (acc_x_r[ACC_W-1:FRAC_W] < (ACC_W-FRAC_W)'(BITMAP_WIDTH)) &&
                     (acc_y_r[ACC_W-1:FRAC_W] < (ACC_W-FRAC_W)'(BITMAP_HEIGHT));

  assign res.address    = alu_sum[ADDR_W-1:0];
  assign res.inside_res = inside_r;

  always_comb begin
    state_nxt  = state_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    inside_nxt = inside_r;
    col_nxt    = col_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    res_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_func) begin
            acc_x_nxt = {{(ACC_W-REF_W){in_ref_x[REF_W-1]}}, in_ref_x};
            acc_y_nxt = {{(ACC_W-REF_W){in_ref_y[REF_W-1]}}, in_ref_y};
          end else if (cfg.affine_enable) begin
            px_nxt     = acc_x_r[FRAC_W +: PX_W];
            py_nxt     = acc_y_r[FRAC_W +: PY_W];
            inside_nxt = in_bounds;
            state_nxt  = S_AX;
          end else begin
            col_nxt    = in_column;
            inside_nxt = 1'b1;
            rem_nxt    = '0;
            cnt_nxt    = CNT_W'(COL_W - 1);
            if (cfg.mosaic_enable && (cfg.mosaic_width != '0)) begin
              state_nxt = S_DIV;
            end else begin
              res_nxt   = ADDR_W'(in_column);
              state_nxt = S_LOFS;
            end
          end
        end
      end
      S_AX: begin
        alu_a     = acc_x_r;
        alu_b     = {{(ACC_W-STEP_W){cfg.step_x[STEP_W-1]}}, cfg.step_x};
        acc_x_nxt = alu_sum;
        state_nxt = S_AY;
      end
      S_AY: begin
        alu_a     = acc_y_r;
        alu_b     = {{(ACC_W-STEP_W){cfg.step_y[STEP_W-1]}}, cfg.step_y};
        acc_y_nxt = alu_sum;
        if (inside_r) begin
          state_nxt = S_ADDX;
        end else begin
          res_nxt   = '0;
          state_nxt = S_FRAME;
        end
      end
      S_ADDX: begin
        alu_a     = row_base;
        alu_b     = ACC_W'(px_r);
        res_nxt   = alu_sum[ADDR_W-1:0];
        state_nxt = S_FRAME;
      end
      S_DIV: begin
        // restoring remainder, one column bit per pass, MSB first
        alu_a   = ACC_W'(trial);
        alu_b   = ACC_W'(cfg.mosaic_width);
        alu_sub = 1'b1;
        rem_nxt = alu_sum[ACC_W-1] ? trial[MW_W-1:0] : alu_sum[MW_W-1:0];
        if (cnt_r == '0) begin
          state_nxt = S_MSUB;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MSUB: begin
        alu_a     = ACC_W'(col_r);
        alu_b     = ACC_W'(rem_r);
        alu_sub   = 1'b1;
        res_nxt   = alu_sum[ADDR_W-1:0];
        state_nxt = S_LOFS;
      end
      S_LOFS: begin
        alu_a     = ACC_W'(res_r);
        alu_b     = ACC_W'(cfg.line_offset);
        res_nxt   = alu_sum[ADDR_W-1:0];
        state_nxt = S_FRAME;
      end
      S_FRAME: begin
        // last add feeds the output register directly; hold here if it is full
        alu_a = ACC_W'(res_r);
        alu_b = (cfg.frame_select && inside_r) ? ACC_W'(FRAME_OFFSET) : '0;
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    inside_r <= inside_nxt;
    col_r    <= col_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

`ifndef SYNTHESIS
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func |=> !in_ready)
    else $error("pixel request did not start a sequence");

  a_ref_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func |=>
      acc_x_r == {{(ACC_W-REF_W){$past(in_ref_x[REF_W-1])}}, $past(in_ref_x)} &&
      acc_y_r == {{(ACC_W-REF_W){$past(in_ref_y[REF_W-1])}}, $past(in_ref_y)})
    else $error("reference load lost");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && !res.inside_res |-> res.address == '0)
    else $error("outside pixel with nonzero address");

  a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_load)
    else $error("result produced while idle");
`endif

endmodule

@@ sv/affine_bitmap_pixel_address.sv @@
// Byte address generator for one 240x160 8-bit bitmap layer. A beat with
// func 0 loads the signed 20.8 reference point into the x/y accumulators
// and gives no result. A beat with func 1 gives one address beat: in
// affine mode the floor of the accumulators is the coordinate (outside the
// bitmap: address 0, inside_res 0), and the accumulators then step by
// step_x/step_y; in plain mode the address is the column (rounded down to
// the mosaic width when mosaic is on) plus line_offset. frame_select adds
// 0xA000 to inside addresses. All adds and subtracts share one 32-bit
// add/subtract unit, one operation per cycle, so a pixel steps through
// AX, AY, ADDX, FRAME in affine mode (no ADDX outside the bitmap), LOFS,
// FRAME in plain mode, and with mosaic first 8 remainder passes over the
// column bits in DIV, then MSUB, LOFS, FRAME. in_ready is low meanwhile,
// and the last step waits if the output register still holds an untaken
// beat. Configuration writes must come while no pixel is in flight.
module affine_bitmap_pixel_address (
  input  logic                                clk,
  input  logic                                rst_n,
  abpa_in_if.sink                             in_ch,
  abpa_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [abpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import abpa_pkg::*;

  abpa_cfg_t         cfg_r, cfg_nxt;
  abpa_res_t         res;
  logic              res_load;
  logic              out_free;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_inside_r;

  // register file: indexes past the list are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_AFFINE_ENABLE: cfg_nxt.affine_enable = cfg_data[0];
        REG_MOSAIC_ENABLE: cfg_nxt.mosaic_enable = cfg_data[0];
        REG_MOSAIC_WIDTH:  cfg_nxt.mosaic_width  = cfg_data[MW_W-1:0];
        REG_LINE_OFFSET:   cfg_nxt.line_offset   = cfg_data[LOFS_W-1:0];
        REG_STEP_X:        cfg_nxt.step_x        = cfg_data[STEP_W-1:0];
        REG_STEP_Y:        cfg_nxt.step_y        = cfg_data[STEP_W-1:0];
        REG_FRAME_SELECT:  cfg_nxt.frame_select  = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.affine_enable <= 1'b0;
      cfg_r.mosaic_enable <= 1'b0;
      cfg_r.mosaic_width  <= '0;
      cfg_r.line_offset   <= '0;
      cfg_r.step_x        <= STEP_W'(256);   // 1.0 in 8.8
      cfg_r.step_y        <= '0;
      cfg_r.frame_select  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  abpa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .in_column (in_ch.column),
    .in_ref_x  (in_ch.ref_x),
    .in_ref_y  (in_ch.ref_y),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_addr_r   <= res.address;
      out_inside_r <= res.inside_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.address    = out_addr_r;
  assign out_ch.inside_res = out_inside_r;

endmodule

@@ verif/abpa_pixel_checker.sv @@
`timescale 1ns / 100ps

module abpa_pixel_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_func,
  input  logic [abpa_pkg::COL_W-1:0]        in_column,
  input  logic [abpa_pkg::REF_W-1:0]        in_ref_x,
  input  logic [abpa_pkg::REF_W-1:0]        in_ref_y,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [abpa_pkg::ADDR_W-1:0]       out_address,
  input  logic                              out_inside_res,
  input  logic                              cfg_we,
  input  logic [abpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import abpa_pkg::*;

  abpa_cfg_t         shadow_cfg;
  logic [ACC_W-1:0]  x_acc;
  logic [ACC_W-1:0]  y_acc;
  abpa_res_t         expected_pixels[$];

  // Address of one pixel request; advances the accumulators in affine mode.
  function automatic abpa_res_t predict_pixel(input logic [COL_W-1:0] col);
    abpa_res_t             r;
    logic [ACC_W-FRAC_W-1:0] px;
    logic [ACC_W-FRAC_W-1:0] py;
    logic [31:0]           a;
    logic [31:0]           c32;
    logic                  outside;
    r.inside_res = 1'b1;
    if (shadow_cfg.affine_enable) begin
      px = x_acc[ACC_W-1:FRAC_W];
      py = y_acc[ACC_W-1:FRAC_W];
      outside = x_acc[ACC_W-1] | y_acc[ACC_W-1] |
                (px >= BITMAP_WIDTH) | (py >= BITMAP_HEIGHT);
      x_acc = x_acc + {{(ACC_W-STEP_W){shadow_cfg.step_x[STEP_W-1]}}, shadow_cfg.step_x};
      y_acc = y_acc + {{(ACC_W-STEP_W){shadow_cfg.step_y[STEP_W-1]}}, shadow_cfg.step_y};
      if (outside) begin
        a = '0;
        r.inside_res = 1'b0;
      end else begin
        a = 32'(px) + 32'(py) * 32'(BITMAP_WIDTH);
        if (shadow_cfg.frame_select) a = a + 32'(FRAME_OFFSET);
      end
    end else begin
      c32 = 32'(col);
      if (shadow_cfg.mosaic_enable && shadow_cfg.mosaic_width != '0)
        c32 = c32 - (c32 % 32'(shadow_cfg.mosaic_width));
      a = c32 + 32'(shadow_cfg.line_offset);
      if (shadow_cfg.frame_select) a = a + 32'(FRAME_OFFSET);
    end
    r.address = a[ADDR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    abpa_res_t want;
    if (!rst_n) begin
      shadow_cfg        = '0;
      shadow_cfg.step_x = 16'sd256;
      x_acc             = '0;
      y_acc             = '0;
      fail_count        = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_AFFINE_ENABLE: shadow_cfg.affine_enable = cfg_data[0];
          REG_MOSAIC_ENABLE: shadow_cfg.mosaic_enable = cfg_data[0];
          REG_MOSAIC_WIDTH:  shadow_cfg.mosaic_width  = cfg_data[MW_W-1:0];
          REG_LINE_OFFSET:   shadow_cfg.line_offset   = cfg_data[LOFS_W-1:0];
          REG_STEP_X:        shadow_cfg.step_x        = cfg_data[STEP_W-1:0];
          REG_STEP_Y:        shadow_cfg.step_y        = cfg_data[STEP_W-1:0];
          REG_FRAME_SELECT:  shadow_cfg.frame_select  = cfg_data[0];
          default: ;
        endcase
      end
      // result side first: a beat leaving now belongs to an older request
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: addr=%0d inside=%0b",
                     out_address, out_inside_res);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_address !== want.address || out_inside_res !== want.inside_res) begin
            if (fail_count < 10)
              $display("pixel mismatch: expected addr=%0d inside=%0b, got addr=%0d inside=%0b",
                       want.address, want.inside_res, out_address, out_inside_res);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (!in_func) begin
          x_acc = {{(ACC_W-REF_W){in_ref_x[REF_W-1]}}, in_ref_x};
          y_acc = {{(ACC_W-REF_W){in_ref_y[REF_W-1]}}, in_ref_y};
        end else begin
          expected_pixels.push_back(predict_pixel(in_column));
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

@@ verif/affine_bitmap_pixel_address_tb.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict only; all prediction and comparison sits in the
// checker instantiated beside the block.
module affine_bitmap_pixel_address_tb;
  import abpa_pkg::*;

  localparam int      QUIET_CYCLES = 16;         // > slowest pixel (mosaic)
  localparam int      HOLD_CYCLES  = 400;        // long sink hold-off
  localparam int      FLAT_PIXELS  = 64;         // flat-out run across the right edge
  localparam longint  TIMEOUT_NS   = 8_000_000;  // several times a clean run

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;

  // sink pacing controls, owned by the stimulus process
  bit          sink_always;
  int unsigned hold_ask;

  abpa_in_if  in_ch();
  abpa_out_if out_ch();

  affine_bitmap_pixel_address dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  abpa_pixel_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_func        (in_ch.func),
    .in_column      (in_ch.column),
    .in_ref_x       (in_ch.ref_x),
    .in_ref_y       (in_ch.ref_y),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_address    (out_ch.address),
    .out_inside_res (out_ch.inside_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("affine_bitmap_pixel_address_tb NOT OK");
    $finish;
  end

  // Result sink pacing. Runs of random length, each with its own ready
  // density (always, mostly, half, rarely). A hold request from the
  // stimulus side drops ready for a long, counted stretch.
  initial begin : sink_pacer
    int          run;
    int          pct;
    int unsigned hold_seen;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (sink_always) begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        run = $urandom_range(1, 64);
        case ($urandom_range(0, 3))
          0:       pct = 100;
          1:       pct = 75;
          2:       pct = 50;
          default: pct = 10;
        endcase
        repeat (run) begin
          out_ch.ready <= ($urandom_range(0, 99) < pct);
          @(negedge clk);
        end
      end
    end
  end

  function automatic abpa_cfg_t make_cfg(input logic aff, input logic mos,
                                         input logic [MW_W-1:0] mw,
                                         input logic [LOFS_W-1:0] lofs,
                                         input logic [STEP_W-1:0] sx,
                                         input logic [STEP_W-1:0] sy,
                                         input logic fs);
    abpa_cfg_t c;
    c.affine_enable = aff;
    c.mosaic_enable = mos;
    c.mosaic_width  = mw;
    c.line_offset   = lofs;
    c.step_x        = sx;
    c.step_y        = sy;
    c.frame_select  = fs;
    return c;
  endfunction

  // All tasks below start and end on a falling edge.

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(input logic f, input logic [COL_W-1:0] col,
                           input logic [REF_W-1:0] rx, input logic [REF_W-1:0] ry);
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.column <= col;
    in_ch.ref_x  <= rx;
    in_ch.ref_y  <= ry;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Sender gap; payload toggles behind a low valid.
  task automatic sender_gap(input int cycles);
    in_ch.valid  <= 1'b0;
    in_ch.func   <= 1'($urandom_range(0, 1));
    in_ch.column <= COL_W'($urandom);
    in_ch.ref_x  <= REF_W'($urandom);
    in_ch.ref_y  <= REF_W'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // Drop valid and wait until no result is owed.
  task automatic await_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Idle point for register writes: no result owed, and a reference load
  // (no result) has had time to land.
  task automatic drain_and_quiesce();
    await_drain();
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // Write every register; unused upper data bits carry junk.
  task automatic write_config(input abpa_cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_AFFINE_ENABLE, {junk[CFG_DATA_W-1:1], c.affine_enable});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MOSAIC_ENABLE, {junk[CFG_DATA_W-1:1], c.mosaic_enable});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MOSAIC_WIDTH, {junk[CFG_DATA_W-1:MW_W], c.mosaic_width});
    write_reg(REG_LINE_OFFSET, c.line_offset);
    write_reg(REG_STEP_X, c.step_x);
    write_reg(REG_STEP_Y, c.step_y);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_FRAME_SELECT, {junk[CFG_DATA_W-1:1], c.frame_select});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One random phase under a fixed register setting. Affine phases are
  // mostly well-formed scan runs (reference load near the bitmap, then a
  // run of pixel beats) with some noise beats mixed in; plain phases are
  // mostly pixel beats with the odd stray reference load.
  task automatic run_random_phase(input abpa_cfg_t c, input int n_items,
                                  input bit hold_mid, input bit pause_mid);
    int                 run_left;
    int                 burst;
    int                 roll;
    int                 v;
    logic               f;
    logic [COL_W-1:0]   col;
    logic [REF_W-1:0]   rx;
    logic [REF_W-1:0]   ry;
    drain_and_quiesce();
    write_config(c);
    run_left = 0;
    burst    = $urandom_range(1, 32);
    for (int i = 0; i < n_items; i++) begin
      // long sink hold-off while beats keep coming: the block backs up
      if (hold_mid && i == n_items / 3) hold_ask++;
      // sender waits for the pipe to empty completely
      if (pause_mid && i == n_items / 2) await_drain();
      col  = COL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(240, 255)
                                                 : $urandom_range(0, 239));
      rx   = REF_W'($urandom);
      ry   = REF_W'($urandom);
      f    = 1'b1;
      roll = $urandom_range(0, 99);
      if (c.affine_enable) begin
        if (roll < 8) begin
          f = 1'($urandom_range(0, 1));
        end else if (run_left == 0) begin
          f  = 1'b0;
          v  = $urandom_range(0, 270 * 256) - 15 * 256;
          rx = v[REF_W-1:0];
          v  = $urandom_range(0, 180 * 256) - 10 * 256;
          ry = v[REF_W-1:0];
          run_left = $urandom_range(1, 40);
        end else begin
          run_left--;
        end
      end else if (roll < 10) begin
        f = 1'b0;
      end
      send_beat(f, col, rx, ry);
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
        burst = $urandom_range(1, 32);
      end
    end
  endtask

  initial begin : stimulus
    abpa_cfg_t c;
    int        v;
    logic [REF_W-1:0] rx;
    logic [REF_W-1:0] ry;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = 1'b0;
    in_ch.column = '0;
    in_ch.ref_x  = '0;
    in_ch.ref_y  = '0;
    sink_always  = 1'b0;
    hold_ask     = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (QUIET_CYCLES) @(negedge clk);

    // ---- directed ----
    // reset setting: plain, no offset
    send_beat(1'b1, 8'd0, '0, '0);
    send_beat(1'b1, 8'd255, '0, '0);

    // affine on, steps left at reset: accumulators start at zero, x step 1.0
    drain_and_quiesce();
    write_reg(REG_AFFINE_ENABLE, 16'h0001);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_beat(1'b1, 8'd0, '0, '0);
    send_beat(1'b1, 8'd0, '0, '0);

    // plain with widest offset, mosaic 16, second frame
    drain_and_quiesce();
    write_config(make_cfg(1'b0, 1'b1, 5'd16, 16'hFFFF, 16'sd256, 16'sd0, 1'b1));
    send_beat(1'b1, 8'd239, '0, '0);
    send_beat(1'b1, 8'd15, '0, '0);
    // reference load with both extremes, no result
    send_beat(1'b0, 8'd0, {1'b1, {(REF_W-1){1'b0}}}, {1'b0, {(REF_W-1){1'b1}}});

    // affine identity walk, second frame: edges and the outside cases
    drain_and_quiesce();
    write_config(make_cfg(1'b1, 1'b0, 5'd0, 16'd0, 16'sd256, 16'sd0, 1'b1));
    send_beat(1'b0, 8'd0, '0, '0);
    send_beat(1'b1, 8'd0, '0, '0);
    send_beat(1'b0, 8'd0, 28'(239 * 256 + 255), 28'(159 * 256 + 255));
    send_beat(1'b1, 8'd0, '0, '0);                 // last pixel of the bitmap
    send_beat(1'b1, 8'd0, '0, '0);                 // x = 240, outside
    send_beat(1'b0, 8'd0, '1, '0);                 // x just below zero
    send_beat(1'b1, 8'd0, '0, '0);
    send_beat(1'b0, 8'd0, '0, '1);                 // y just below zero
    send_beat(1'b1, 8'd0, '0, '0);
    send_beat(1'b0, 8'd0, 28'(5 * 256), 28'(160 * 256));  // y = 160
    send_beat(1'b1, 8'd0, '0, '0);
    send_beat(1'b0, 8'd0, {1'b0, {(REF_W-1){1'b1}}}, {1'b0, {(REF_W-1){1'b1}}});
    send_beat(1'b1, 8'd0, '0, '0);

    // extreme steps, first frame: stays inside, then walks off the left edge
    drain_and_quiesce();
    write_config(make_cfg(1'b1, 1'b0, 5'd0, 16'd0, 16'h8000, 16'h7FFF, 1'b0));
    send_beat(1'b0, 8'd0, 28'(200 * 256), 28'(10 * 256));
    repeat (3) send_beat(1'b1, 8'd0, '0, '0);

    // ---- random phases ----
    for (int p = 0; p < 13; p++) begin
      case (p)
        0:  c = make_cfg(1'b0, 1'b0, 5'd0, 16'd0, 16'sd256, 16'sd0, 1'b0);
        1:  c = make_cfg(1'b0, 1'b1, 5'd1, 16'hFFFF, 16'sd256, 16'sd0, 1'b1);
        2:  c = make_cfg(1'b0, 1'b1, 5'd16, 16'($urandom), 16'sd256, 16'sd0,
                         1'($urandom_range(0, 1)));
        3:  c = make_cfg(1'b0, 1'b1, 5'd31, 16'($urandom), 16'($urandom),
                         16'($urandom), 1'b1);
        4:  c = make_cfg(1'b0, 1'b1, 5'd0, 16'd38399, 16'($urandom),
                         16'($urandom), 1'b0);
        5:  c = make_cfg(1'b0, 1'b0, 5'd7, 16'($urandom), 16'($urandom),
                         16'($urandom), 1'b1);
        6:  c = make_cfg(1'b1, 1'b0, 5'd0, 16'd0, 16'sd256, 16'sd0, 1'b0);
        7:  c = make_cfg(1'b1, 1'b1, 5'd3, 16'd100, 16'h8000, 16'h7FFF, 1'b1);
        8:  c = make_cfg(1'b1, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        default: begin
          c = make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       MW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
                                                         : $urandom_range(0, 16)),
                       16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom_range(0, 1)));
          // gentle steps in about half the phases, so scan runs stay on the bitmap
          if ($urandom_range(0, 1) == 0) begin
            v = $urandom_range(0, 1024) - 512;
            c.step_x = v[STEP_W-1:0];
            v = $urandom_range(0, 1024) - 512;
            c.step_y = v[STEP_W-1:0];
          end
        end
      endcase
      run_random_phase(c, $urandom_range(110, 160), p == 2 || p == 7, p == 9);
    end

    // ---- flat-out scan ----
    // Identity steps from column 200 of row 20, second frame; the run
    // crosses the right edge. Sink and sender run flat out.
    drain_and_quiesce();
    write_config(make_cfg(1'b1, 1'b0, 5'd0, 16'd0, 16'sd256, 16'sd0, 1'b1));
    sink_always = 1'b1;
    v  = 200 * 256 + 128;
    rx = v[REF_W-1:0];
    v  = 20 * 256;
    ry = v[REF_W-1:0];
    send_beat(1'b0, 8'd0, rx, ry);
    for (int k = 0; k < FLAT_PIXELS; k++)
      send_beat(1'b1, COL_W'($urandom), REF_W'($urandom), REF_W'($urandom));
    sink_always = 1'b0;

    // ---- end of run ----
    await_drain();
    repeat (QUIET_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("affine_bitmap_pixel_address_tb OK");
    else
      $display("affine_bitmap_pixel_address_tb NOT OK");
    $finish;
  end

endmodule
